### rtl/core/spbm_pkg.sv
// spbm_pkg: shared types and constants for the ssd patch best matcher
// holds the request/result structs, register indexes and field widths
// no dependencies
package spbm_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned CoordW = 11;
  localparam int unsigned DimW   = 12;
  localparam int unsigned SumW   = 23;
  localparam int unsigned SqW    = 2 * PixW;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = SumW;

  // corners must sit at least this far inside their image
  localparam int unsigned BorderMargin = 11;

  localparam logic [CfgIdxW-1:0] CfgWidthA  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHeightA = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWidthB  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHeightB = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRangeX  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRangeY  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSumLim  = 3'd6;

  localparam logic [DimW-1:0]   WidthReset  = DimW'(640);
  localparam logic [DimW-1:0]   HeightReset = DimW'(480);
  localparam logic [CoordW-1:0] RangeReset  = CoordW'(2047);
  localparam logic [SumW-1:0]   SumLimReset = SumW'(7868026);

  typedef struct packed {
    logic [PixW-1:0]   pixel_a;
    logic [PixW-1:0]   pixel_b;
    logic [IdxW-1:0]   query_index;
    logic [CoordW-1:0] query_x;
    logic [CoordW-1:0] query_y;
    logic [IdxW-1:0]   cand_index;
    logic [CoordW-1:0] cand_x;
    logic [CoordW-1:0] cand_y;
    logic              last_pixel;
    logic              last_candidate;
  } spbm_req_t;

  typedef struct packed {
    logic [IdxW-1:0] result_query;
    logic [IdxW-1:0] match_index;
    logic [SumW-1:0] best_sum;
    logic            matched;
  } spbm_rsp_t;

endpackage

### rtl/core/ssd_patch_best_matcher_core.sv
// ssd_patch_best_matcher_core: streaming sum-of-squared-differences matcher
// two pipeline stages and an output register; depends on spbm_pkg
//
// usage:
//   the request channel carries one pixel pair per request, together with the
//   query and candidate corner data and the end-of-patch / end-of-query marks
//   a request is taken on a rising edge with in_valid_i high and in_stall_o low
//   the result channel gives one result per query, on the request that closes
//   the last candidate's patch; taken when out_valid_o high, out_stall_i low
//   a closing request goes through stage 1 and then the output register;
//   requests are taken one per cycle while in_stall_o is low, and the
//   accumulate-and-compare loop keeps the running sum and best candidate
//   when the receiver stalls, requests that close no query keep flowing; only
//   a closing request waits in the first stage while an older result is held
//   configuration registers are written through cfg_we_i / cfg_index_i /
//   cfg_data_i, by the user only while idle; the block does not check this;
//   unknown indexes are ignored; reset puts the registers at their defaults,
//   clears the running sum, the best candidate and the pipeline valid bits
module ssd_patch_best_matcher_core
  import spbm_pkg::*;
#(
  parameter int unsigned CornerMargin = BorderMargin
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spbm_req_t           in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spbm_rsp_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [DimW-1:0]   width_a_q, height_a_q, width_b_q, height_b_q;
  logic [CoordW-1:0] range_x_q, range_y_q;
  logic [SumW-1:0]   sum_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_a_q   <= WidthReset;
      height_a_q  <= HeightReset;
      width_b_q   <= WidthReset;
      height_b_q  <= HeightReset;
      range_x_q   <= RangeReset;
      range_y_q   <= RangeReset;
      sum_limit_q <= SumLimReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWidthA:  width_a_q   <= cfg_data_i[DimW-1:0];
        CfgHeightA: height_a_q  <= cfg_data_i[DimW-1:0];
        CfgWidthB:  width_b_q   <= cfg_data_i[DimW-1:0];
        CfgHeightB: height_b_q  <= cfg_data_i[DimW-1:0];
        CfgRangeX:  range_x_q   <= cfg_data_i[CoordW-1:0];
        CfgRangeY:  range_y_q   <= cfg_data_i[CoordW-1:0];
        CfgSumLim:  sum_limit_q <= cfg_data_i[SumW-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: square of the pixel difference and the eligibility tests
  logic [PixW-1:0]   pix_diff;
  logic [SqW-1:0]    sq_d;
  logic [CoordW-1:0] dx, dy;
  logic              elig_d;
  logic              in_x_a, in_y_a, in_x_b, in_y_b;

  function automatic logic corner_inside(logic [CoordW-1:0] c, logic [DimW-1:0] dim);
    logic [DimW:0] far_edge;
    far_edge = (DimW+1)'(c) + (DimW+1)'(CornerMargin);
    return ((DimW+1)'(c) >= (DimW+1)'(CornerMargin)) && (far_edge < {1'b0, dim});
  endfunction

  always_comb begin
    pix_diff = (in_data_i.pixel_a > in_data_i.pixel_b) ?
               in_data_i.pixel_a - in_data_i.pixel_b :
               in_data_i.pixel_b - in_data_i.pixel_a;
    sq_d     = pix_diff * pix_diff;
    dx       = (in_data_i.query_x > in_data_i.cand_x) ?
               in_data_i.query_x - in_data_i.cand_x :
               in_data_i.cand_x - in_data_i.query_x;
    dy       = (in_data_i.query_y > in_data_i.cand_y) ?
               in_data_i.query_y - in_data_i.cand_y :
               in_data_i.cand_y - in_data_i.query_y;
    in_x_a   = corner_inside(in_data_i.query_x, width_a_q);
    in_y_a   = corner_inside(in_data_i.query_y, height_a_q);
    in_x_b   = corner_inside(in_data_i.cand_x, width_b_q);
    in_y_b   = corner_inside(in_data_i.cand_y, height_b_q);
    elig_d   = (dx <= range_x_q) && (dy <= range_y_q) &&
               in_x_a && in_y_a && in_x_b && in_y_b;
  end

  logic            s1_valid_q;
  logic [SqW-1:0]  sq_q;
  logic            elig_q;
  logic            lp_q, lc_q;
  logic [IdxW-1:0] qi_q, ci_q;
  logic            s1_go;
  logic            out_free;
  logic            in_accept;

  assign out_free   = !out_valid_o || !out_stall_i;
  // only a query-closing request needs room in the output register
  assign s1_go      = s1_valid_q && (!(lp_q && lc_q) || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sq_q   <= sq_d;
      elig_q <= elig_d;
      lp_q   <= in_data_i.last_pixel;
      lc_q   <= in_data_i.last_candidate;
      qi_q   <= in_data_i.query_index;
      ci_q   <= in_data_i.cand_index;
    end
  end

  // stage 2: accumulate, keep the best eligible candidate, close the query
  logic [SumW-1:0] run_sum_q, run_sum_d;
  logic [SumW-1:0] best_sum_q, best_sum_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            have_best_q, have_best_d;
  logic [SumW:0]   sum_wide;
  logic [SumW-1:0] sum_sat;
  logic [SumW-1:0] upd_sum;
  logic [IdxW-1:0] upd_idx;
  logic            upd_have;
  logic            take_new;
  logic            out_load;
  spbm_rsp_t       rsp_d;

  always_comb begin
    sum_wide  = (SumW+1)'(run_sum_q) + (SumW+1)'(sq_q);
    // saturate at the top of the sum range
    sum_sat   = sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];
    take_new  = lp_q && elig_q && (!have_best_q || sum_sat < best_sum_q);
    upd_sum   = take_new ? sum_sat : best_sum_q;
    upd_idx   = take_new ? ci_q : best_idx_q;
    upd_have  = take_new || have_best_q;

    rsp_d.result_query = qi_q;
    rsp_d.match_index  = upd_have ? upd_idx : '0;
    rsp_d.best_sum     = upd_have ? upd_sum : '0;
    rsp_d.matched      = upd_have && (upd_sum < sum_limit_q);

    run_sum_d   = lp_q ? '0 : sum_sat;
    best_sum_d  = upd_sum;
    best_idx_d  = upd_idx;
    have_best_d = upd_have;
    if (lp_q && lc_q) begin
      best_sum_d  = '0;
      best_idx_d  = '0;
      have_best_d = 1'b0;
    end
    out_load = s1_go && lp_q && lc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sum_q   <= '0;
      best_sum_q  <= '0;
      best_idx_q  <= '0;
      have_best_q <= 1'b0;
    end else if (s1_go) begin
      run_sum_q   <= run_sum_d;
      best_sum_q  <= best_sum_d;
      best_idx_q  <= best_idx_d;
      have_best_q <= have_best_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_o <= rsp_d;
    end
  end

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for ssd_patch_best_matcher_core
// streams pixel-pair requests under several register settings and stall patterns;
// a scoreboard class predicts each query's best match; depends on spbm_pkg
module tb_top;
  import spbm_pkg::*;

  localparam int PatchRadius   = 5;
  localparam int Window        = (2 * PatchRadius + 1) * (2 * PatchRadius + 1);
  localparam int Margin        = int'(BorderMargin);
  localparam int SumMax        = (1 << SumW) - 1;
  localparam int CoordMax      = (1 << CoordW) - 1;
  localparam int ItemsPerPhase = 225;
  localparam int NumPhases     = 8;
  localparam int CycleLimit    = 500000;
  localparam int ReportLimit   = 10;

  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  class match_scoreboard;
    logic [DimW-1:0]   width_a, height_a, width_b, height_b;
    logic [CoordW-1:0] range_x, range_y;
    logic [SumW-1:0]   sum_limit;
    int                patch_sum;
    int                best_sum;
    logic [IdxW-1:0]   best_cand;
    bit                have_best;
    spbm_rsp_t         pending[$];
    int                errors;

    function new();
      width_a   = WidthReset;
      height_a  = HeightReset;
      width_b   = WidthReset;
      height_b  = HeightReset;
      range_x   = RangeReset;
      range_y   = RangeReset;
      sum_limit = SumLimReset;
      patch_sum = 0;
      best_sum  = 0;
      best_cand = '0;
      have_best = 1'b0;
      errors    = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgWidthA:  width_a   = val[DimW-1:0];
        CfgHeightA: height_a  = val[DimW-1:0];
        CfgWidthB:  width_b   = val[DimW-1:0];
        CfgHeightB: height_b  = val[DimW-1:0];
        CfgRangeX:  range_x   = val[CoordW-1:0];
        CfgRangeY:  range_y   = val[CoordW-1:0];
        CfgSumLim:  sum_limit = val[SumW-1:0];
        default: ;
      endcase
    endfunction

    function bit near_enough(int a, int b, int lim);
      return (a > b ? a - b : b - a) <= lim;
    endfunction

    function bit clear_of_border(int c, int dim);
      return c >= Margin && c + Margin < dim;
    endfunction

    function void note_request(spbm_req_t r);
      int        diff;
      bit        ok;
      spbm_rsp_t res;
      diff = int'(r.pixel_a) - int'(r.pixel_b);
      patch_sum = patch_sum + diff * diff;
      if (patch_sum > SumMax) patch_sum = SumMax;
      if (!r.last_pixel) return;
      // eligibility uses the corner data on the closing pixel of the patch
      ok = near_enough(int'(r.query_x), int'(r.cand_x), int'(range_x)) &&
           near_enough(int'(r.query_y), int'(r.cand_y), int'(range_y)) &&
           clear_of_border(int'(r.query_x), int'(width_a)) &&
           clear_of_border(int'(r.query_y), int'(height_a)) &&
           clear_of_border(int'(r.cand_x), int'(width_b)) &&
           clear_of_border(int'(r.cand_y), int'(height_b));
      if (ok && (!have_best || patch_sum < best_sum)) begin
        have_best = 1'b1;
        best_sum  = patch_sum;
        best_cand = r.cand_index;
      end
      patch_sum = 0;
      if (!r.last_candidate) return;
      res.result_query = r.query_index;
      res.match_index  = have_best ? best_cand : '0;
      res.best_sum     = have_best ? SumW'(best_sum) : '0;
      res.matched      = have_best && (best_sum < int'(sum_limit));
      pending = {pending, res};
      have_best = 1'b0;
      best_sum  = 0;
      best_cand = '0;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= ReportLimit) $display("mismatch: %s", msg);
    endfunction

    function void check_match(spbm_rsp_t got);
      spbm_rsp_t want;
      if (pending.size() == 0) begin
        note_error($sformatf("result with no query waiting: query %0d index %0d sum %0d matched %0b",
                             got.result_query, got.match_index, got.best_sum, got.matched));
        return;
      end
      want = pending.pop_front();
      if (got.result_query !== want.result_query || got.match_index !== want.match_index ||
          got.best_sum !== want.best_sum || got.matched !== want.matched)
        note_error($sformatf({"query %0d: expected index %0d sum %0d matched %0b, ",
                              "got query %0d index %0d sum %0d matched %0b"},
                             want.result_query, want.match_index, want.best_sum, want.matched,
                             got.result_query, got.match_index, got.best_sum, got.matched));
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                req_valid = 1'b0;
  logic                req_stall;
  spbm_req_t           req       = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  spbm_rsp_t           rsp;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_count     = 0;
  int cycle_count    = 0;

  match_scoreboard sb = new();

  ssd_patch_best_matcher_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_data_o  (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_valid && !rsp_stall) sb.check_match(rsp);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_request(input spbm_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_register(idx, val);
    @(negedge clk);
  endtask

  // wait for every expected result, then let the pipeline run empty
  task automatic settle();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic apply_phase(input int phase);
    int wa, ha, wb, hb, rx, ry, lim;
    wa  = $urandom_range(16, 2048);
    ha  = $urandom_range(16, 2048);
    wb  = $urandom_range(16, 2048);
    hb  = $urandom_range(16, 2048);
    rx  = $urandom_range(1) ? $urandom_range(0, 64) : $urandom_range(0, CoordMax);
    ry  = $urandom_range(1) ? $urandom_range(0, 64) : $urandom_range(0, CoordMax);
    lim = $urandom_range(0, 300000);
    case (phase)
      0: begin
        wa = 640; ha = 480; wb = 640; hb = 480; rx = 100; ry = 50; lim = 65025;
      end
      1: begin
        wa = 640; ha = 480; wb = 640; hb = 480; rx = 2047; ry = 2047; lim = 7868026;
      end
      2: begin
        // all-ones data, each register keeps only its own bits
        wa = SumMax; ha = SumMax; wb = SumMax; hb = SumMax;
        rx = SumMax; ry = SumMax; lim = SumMax;
      end
      3: begin
        wa = 23; ha = 24; wb = 24; hb = 23; rx = 0; ry = 1;
      end
      4: begin
        // first image too small for any corner to clear the border
        wa = 22; ha = 0; lim = 0;
      end
      default: ;
    endcase
    write_reg(CfgWidthA,  CfgDataW'(wa));
    write_reg(CfgHeightA, CfgDataW'(ha));
    write_reg(CfgWidthB,  CfgDataW'(wb));
    write_reg(CfgHeightB, CfgDataW'(hb));
    write_reg(CfgRangeX,  CfgDataW'(rx));
    write_reg(CfgRangeY,  CfgDataW'(ry));
    write_reg(CfgSumLim,  CfgDataW'(lim));
    write_reg(CfgUnused,  CfgDataW'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic spbm_req_t pixel_pair(input int pa, pb, qi, qx, qy, ci, cx, cy,
                                           input bit lp, lc);
    spbm_req_t r;
    r.pixel_a        = PixW'(pa);
    r.pixel_b        = PixW'(pb);
    r.query_index    = IdxW'(qi);
    r.query_x        = CoordW'(qx);
    r.query_y        = CoordW'(qy);
    r.cand_index     = IdxW'(ci);
    r.cand_x         = CoordW'(cx);
    r.cand_y         = CoordW'(cy);
    r.last_pixel     = lp;
    r.last_candidate = lc;
    return r;
  endfunction

  // runs with 640x480 images, range 100/50 and limit 65025
  task automatic run_directed();
    // tie keeps the earlier candidate; offsets one past the range are rejected
    push_request(pixel_pair(255,   0, 1023, 100, 100,    5, 100, 100, 1, 0));
    push_request(pixel_pair(  0, 255, 1023, 100, 100, 1023, 200, 150, 1, 0));
    push_request(pixel_pair(  0,   0, 1023, 100, 100,    7, 201, 100, 1, 0));
    push_request(pixel_pair(  0,   0, 1023, 100, 100,    6, 100, 151, 1, 0));
    // end-of-query mark without end of patch is ignored
    push_request(pixel_pair( 10,  12, 1023, 100, 100,    8,  11,  60, 0, 1));
    push_request(pixel_pair(  0,   0, 1023, 100, 100,    8,  11,  60, 1, 1));
    // candidates just outside the border on both sides: nothing eligible
    push_request(pixel_pair(  7,   7,    0,  11,  11,    3,  10,  11, 1, 0));
    push_request(pixel_pair(  7,   7,    0,  11,  11,    4, 629,  11, 1, 1));
    // sum equal to the limit does not match, one below does
    push_request(pixel_pair(255,   0,  512, 628, 468,    9, 628, 468, 1, 1));
    push_request(pixel_pair(254,   0,  511, 628, 468,    1, 628, 468, 1, 1));
    // corner data on the opening pixel is not used
    push_request(pixel_pair(255,   0,    0, 2047, 2047, 1023, 2047, 2047, 0, 0));
    push_request(pixel_pair(255,   0,  513,  11,  11,    0,  11,  11, 1, 1));
    // query corner on the bottom border
    push_request(pixel_pair(  3,   9,  514, 300, 469,    2, 300, 468, 1, 1));
    push_request(pixel_pair(170,  85,  682, 2047, 2047, 341, 2047, 2047, 1, 1));
  endtask

  function automatic logic [CoordW-1:0] pick_coord(input int dim);
    int hi;
    int c;
    int roll;
    hi   = dim - 1 - Margin;
    roll = $urandom_range(99);
    if (roll < 70 && hi >= Margin) begin
      c = $urandom_range(Margin, hi > CoordMax ? CoordMax : hi);
    end else if (roll < 85) begin
      case ($urandom_range(3))
        0:       c = Margin - 1;
        1:       c = Margin;
        2:       c = hi;
        default: c = hi + 1;
      endcase
    end else begin
      c = $urandom_range(CoordMax);
    end
    if (c < 0) c = 0;
    if (c > CoordMax) c = CoordMax;
    return CoordW'(c);
  endfunction

  function automatic logic [CoordW-1:0] near_coord(input int q, input int rng, input int dim);
    int off;
    int c;
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return pick_coord(dim);
    if (roll < 45) off = rng + $urandom_range(1);
    else off = $urandom_range(rng < 200 ? rng + 1 : 200);
    if ($urandom_range(1)) off = -off;
    c = q + off;
    if (c < 0) c = 0;
    if (c > CoordMax) c = CoordMax;
    return CoordW'(c);
  endfunction

  task automatic run_query();
    spbm_req_t         r;
    int                n_cand;
    int                len;
    int                mode;
    bit                garbage;
    logic [PixW-1:0]   a, b, t;
    logic [PixW-1:0]   pix_a[$];
    logic [PixW-1:0]   pix_b[$];
    logic [IdxW-1:0]   qi;
    logic [CoordW-1:0] qx, qy, cx, cy;
    qi     = IdxW'($urandom);
    qx     = pick_coord(int'(sb.width_a));
    qy     = pick_coord(int'(sb.height_a));
    n_cand = $urandom_range(1, 4);
    for (int c = 0; c < n_cand; c++) begin
      // sometimes replay the previous patch so two candidates tie
      if (pix_a.size() == 0 || $urandom_range(99) >= 15) begin
        mode = $urandom_range(99);
        len  = (mode < 94) ? $urandom_range(1, 6) : (mode < 98) ? Window : $urandom_range(130, 140);
        pix_a.delete();
        pix_b.delete();
        for (int k = 0; k < len; k++) begin
          if (len > Window) begin
            a = '1;
            b = '0;
            if ($urandom_range(1)) begin
              t = a; a = b; b = t;
            end
          end else begin
            a = PixW'($urandom);
            case ($urandom_range(3))
              0, 1: b = PixW'($urandom);
              2:    b = a ^ PixW'($urandom_range(3));
              default: begin
                a = $urandom_range(1) ? '1 : '0;
                b = $urandom_range(1) ? '1 : '0;
              end
            endcase
          end
          pix_a = {pix_a, a};
          pix_b = {pix_b, b};
        end
      end
      cx = near_coord(int'(qx), int'(sb.range_x), int'(sb.width_b));
      cy = near_coord(int'(qy), int'(sb.range_y), int'(sb.height_b));
      r.cand_index = IdxW'($urandom);
      for (int k = 0; k < pix_a.size(); k++) begin
        r.pixel_a    = pix_a[k];
        r.pixel_b    = pix_b[k];
        r.last_pixel = (k == pix_a.size() - 1);
        garbage      = !r.last_pixel && ($urandom_range(4) == 0);
        r.query_index = garbage ? IdxW'($urandom) : qi;
        r.query_x     = garbage ? CoordW'($urandom) : qx;
        r.query_y     = garbage ? CoordW'($urandom) : qy;
        r.cand_x      = garbage ? CoordW'($urandom) : cx;
        r.cand_y      = garbage ? CoordW'($urandom) : cy;
        r.last_candidate = r.last_pixel ? (c == n_cand - 1) : ($urandom_range(9) == 0);
        push_request(r);
      end
    end
  endtask

  initial begin
    int phase;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    apply_phase(0);
    run_directed();
    for (phase = 1; phase <= NumPhases; phase++) begin
      settle();
      apply_phase(phase);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      sent_count = 0;
      while (sent_count < ItemsPerPhase) run_query();
    end
    settle();
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
